// ===== hdl/rmsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsr_pkg
// Shared constants, codes and types of the range map split/relabel core.
// ----------------------------------------------------------------------------
package rmsr_pkg;

   // table geometry
   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = 64;
   localparam int LABEL_W     = 16;
   localparam int SEL_W       = 6;   // width of the read_index field
   localparam int ENTRY_W     = 2 * ADDR_W + LABEL_W;

   // stream word layout
   localparam int REQ_FIELDS_W = 2 * ADDR_W + 2 * LABEL_W + SEL_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 7 + 16 + 2 * ADDR_W + LABEL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // operation codes
   localparam logic [1:0] OP_APPEND  = 2'd0;
   localparam logic [1:0] OP_RELABEL = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // one table entry as stored in the memory, start in the low bits
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [ADDR_W-1:0]  end_addr;
      logic [ADDR_W-1:0]  start_addr;
   } entry_type;

endpackage

// ===== hdl/rmsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rmsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/range_map_split_relabel_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_map_split_relabel_core
// Table of address ranges with append, read back and relabel with split.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake             Contents
// req_*     in   tvalid/tready         op in tuser, range and labels in tdata
// rsp_*     out  tvalid/tready         status in tuser, count, top label and slot in tdata
//
// Append, op 3 and a relabel on an empty table go straight to the response;
// a valid read first registers its entry. Relabel scans one entry per cycle
// from a single RAM read port; a hit leads to the split choice and the writes.
// Synchronous reset clears the entry count, the label high mark and control.
// A finished result waits in the output register while the next word is
// accepted; a second result holds the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module range_map_split_relabel_core
   import rmsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [63:0] range_start, [127:64] range_end, [143:128] new_label,
   // [159:144] old_label, [165:160] read_index, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [1:0]            req_tuser,
   // response
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [6:0] entry_total, [22:7] largest_label, [86:23] slot_start,
   // [150:87] slot_end, [166:151] slot_label, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // relabel kinds
   localparam logic [1:0] K_WHOLE = 2'd0;
   localparam logic [1:0] K_HEAD  = 2'd1;
   localparam logic [1:0] K_TAIL  = 2'd2;
   localparam logic [1:0] K_MID   = 2'd3;

   // request fields
   logic [ADDR_W-1:0]  req_start;
   logic [ADDR_W-1:0]  req_end;
   logic [LABEL_W-1:0] req_new_label;
   logic [LABEL_W-1:0] req_old_label;
   logic [SEL_W-1:0]   req_read_index;

   assign req_start      = req_tdata[ADDR_W-1:0];
   assign req_end        = req_tdata[2*ADDR_W-1:ADDR_W];
   assign req_new_label  = req_tdata[2*ADDR_W+LABEL_W-1:2*ADDR_W];
   assign req_old_label  = req_tdata[2*ADDR_W+2*LABEL_W-1:2*ADDR_W+LABEL_W];
   assign req_read_index = req_tdata[REQ_FIELDS_W-1:2*ADDR_W+2*LABEL_W];

   // control and working registers
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  s_ff, s_in;
   logic [ADDR_W-1:0]  e_ff, e_in;
   logic [LABEL_W-1:0] nl_ff, nl_in;
   logic [LABEL_W-1:0] ol_ff, ol_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               seen_ff, seen_in;
   entry_type          hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [1:0]         kind_ff, kind_in;
   logic [1:0]         step_ff, step_in;
   logic [1:0]         last_ff, last_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [LABEL_W-1:0] top_ff, top_in;
   logic [1:0]         status_ff, status_in;
   entry_type          slot_ff, slot_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [CNT_W-1:0]   rsp_used_ff;
   logic [LABEL_W-1:0] rsp_top_ff;
   entry_type          rsp_slot_ff;
   logic               rsp_load;

   // memory port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type          rd_entry;

   assign rd_entry = entry_type'(rd_raw);

   rmsr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // scan compare terms
   logic lab_eq;
   logic contains;
   logic last_cmp;

   assign lab_eq   = (rd_entry.label == ol_ff);
   assign contains = (rd_entry.start_addr <= s_ff) && (rd_entry.end_addr >= e_ff);
   assign last_cmp = ({1'b0, cmp_idx_ff} == (IDX_W + 1)'(used_ff - CNT_W'(1)));

   // sequencer
   always_comb begin
      state_in   = state_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      nl_in      = nl_ff;
      ol_in      = ol_ff;
      issue_in   = issue_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      seen_in    = seen_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      kind_in    = kind_ff;
      step_in    = step_ff;
      last_in    = last_ff;
      used_in    = used_ff;
      top_in     = top_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      wr_en      = 1'b0;
      wr_addr    = hit_idx_ff;
      wr_data    = hit_ff;
      rd_addr    = issue_ff[IDX_W-1:0];
      rsp_load   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // relabel range: order the ends, make the end inclusive
               if (req_start > req_end) begin
                  s_in = req_end;
                  e_in = req_start - ADDR_W'(1);
               end else begin
                  s_in = req_start;
                  e_in = req_end - ADDR_W'(1);
               end
               nl_in      = req_new_label;
               ol_in      = req_old_label;
               slot_in    = '0;
               status_in  = ST_OK;
               seen_in    = 1'b0;
               cmp_vld_in = 1'b0;
               case (req_tuser)
                  OP_APPEND: begin
                     if (used_ff < CNT_W'(MAX_ENTRIES)) begin
                        wr_en              = 1'b1;
                        wr_addr            = used_ff[IDX_W-1:0];
                        wr_data.start_addr = req_start;
                        wr_data.end_addr   = req_end;
                        wr_data.label      = req_new_label;
                        used_in            = used_ff + CNT_W'(1);
                     end else begin
                        status_in = ST_FULL;
                     end
                     state_in = S_DONE;
                  end
                  OP_RELABEL: begin
                     if (used_ff == '0) begin
                        status_in = ST_INVALID;
                        state_in  = S_DONE;
                     end else begin
                        // first entry read goes out now
                        rd_addr    = '0;
                        cmp_vld_in = 1'b1;
                        cmp_idx_in = '0;
                        issue_in   = CNT_W'(1);
                        state_in   = S_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (32'(req_read_index) < 32'(used_ff)) begin
                        rd_addr  = IDX_W'(req_read_index);
                        state_in = S_READ;
                     end else begin
                        status_in = ST_INVALID;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_READ: begin
            slot_in  = rd_entry;
            state_in = S_DONE;
         end

         S_SCAN: begin
            // next read in flight while the previous word is compared
            rd_addr    = issue_ff[IDX_W-1:0];
            cmp_vld_in = (issue_ff < used_ff);
            cmp_idx_in = issue_ff[IDX_W-1:0];
            issue_in   = issue_ff + CNT_W'(1);
            if (cmp_vld_ff) begin
               if (lab_eq && contains) begin
                  hit_in     = rd_entry;
                  hit_idx_in = cmp_idx_ff;
                  state_in   = S_DECIDE;
               end else begin
                  if (lab_eq) begin
                     seen_in = 1'b1;
                  end
                  if (last_cmp) begin
                     status_in = (seen_ff || lab_eq) ? ST_OUTSIDE : ST_INVALID;
                     state_in  = S_DONE;
                  end
               end
            end
         end

         S_DECIDE: begin
            // pick the split and check room for the new pieces
            step_in = 2'd0;
            if ((s_ff == hit_ff.start_addr) && (e_ff == hit_ff.end_addr)) begin
               kind_in  = K_WHOLE;
               last_in  = 2'd0;
               state_in = S_WRITE;
            end else if ((s_ff == hit_ff.start_addr) || (e_ff == hit_ff.end_addr)) begin
               kind_in = (s_ff == hit_ff.start_addr) ? K_HEAD : K_TAIL;
               last_in = 2'd1;
               if (used_ff < CNT_W'(MAX_ENTRIES)) begin
                  state_in = S_WRITE;
               end else begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end
            end else begin
               kind_in = K_MID;
               last_in = 2'd2;
               if (used_ff <= CNT_W'(MAX_ENTRIES - 2)) begin
                  state_in = S_WRITE;
               end else begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end
            end
         end

         S_WRITE: begin
            wr_en = 1'b1;
            case (step_ff)
               2'd0: begin
                  // rewrite the containing entry
                  wr_addr = hit_idx_ff;
                  wr_data = hit_ff;
                  case (kind_ff)
                     K_WHOLE: wr_data.label      = nl_ff;
                     K_HEAD:  wr_data.start_addr = e_ff + ADDR_W'(1);
                     default: wr_data.end_addr   = s_ff - ADDR_W'(1);
                  endcase
               end
               2'd1: begin
                  // relabelled piece
                  wr_addr            = used_ff[IDX_W-1:0];
                  wr_data.start_addr = s_ff;
                  wr_data.end_addr   = e_ff;
                  wr_data.label      = nl_ff;
               end
               default: begin
                  // upper remainder of a middle split
                  wr_addr            = used_ff[IDX_W-1:0] + IDX_W'(1);
                  wr_data.start_addr = e_ff + ADDR_W'(1);
                  wr_data.end_addr   = hit_ff.end_addr;
                  wr_data.label      = hit_ff.label;
               end
            endcase
            if (step_ff == last_ff) begin
               used_in   = used_ff + CNT_W'(step_ff);
               if (top_ff < nl_ff) begin
                  top_in = nl_ff;
               end
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      e_ff       <= e_in;
      nl_ff      <= nl_in;
      ol_ff      <= ol_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      seen_ff    <= seen_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      kind_ff    <= kind_in;
      step_ff    <= step_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
   end

   // output word
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_used_ff   <= used_ff;
         rsp_top_ff    <= top_ff;
         rsp_slot_ff   <= slot_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_slot_ff.label,
                                    rsp_slot_ff.end_addr,
                                    rsp_slot_ff.start_addr,
                                    16'(rsp_top_ff),
                                    7'(rsp_used_ff)});

endmodule

// ===== sim/range_map_split_relabel_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_map_split_relabel_core_test
// Self-checking bench for the range map with append, read back and relabel.
// Words are drawn against a planning copy of the table, so most relabels land
// inside live entries and cut them whole, at one end or in the middle. A
// second copy of the table is advanced word by word as the core accepts
// requests and predicts each response. Both stream sides idle in phases, the
// receiver holds off once for a long stretch, and the table is driven full.
// ----------------------------------------------------------------------------
module range_map_split_relabel_core_test;
   import rmsr_pkg::*;

   localparam int RUN_LIMIT     = 1_000_000;
   localparam int RANDOM_WORDS  = 1650;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 80;
   localparam int REPORT_MAX    = 10;

   // which copy of the table a prediction works on
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   // op code the core does not define
   localparam logic [1:0] OP_SPARE = 2'd3;

   // where a relabel cuts its entry
   localparam int CUT_WHOLE  = 0;
   localparam int CUT_LEFT   = 1;
   localparam int CUT_RIGHT  = 2;
   localparam int CUT_MIDDLE = 3;

   // idling phases
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   localparam logic [ADDR_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [1:0]         op;
      logic [SEL_W-1:0]   index;
      logic [LABEL_W-1:0] old_label;
      logic [LABEL_W-1:0] new_label;
      logic [ADDR_W-1:0]  range_end;
      logic [ADDR_W-1:0]  range_start;
   } map_cmd_t;

   typedef struct packed {
      logic [1:0]         status;
      logic [LABEL_W-1:0] slot_label;
      logic [ADDR_W-1:0]  slot_end;
      logic [ADDR_W-1:0]  slot_start;
      logic [LABEL_W-1:0] largest_label;
      logic [CNT_W-1:0]   entry_total;
   } map_reply_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // two copies of the range table: planning and checking
   logic [ADDR_W-1:0]  lo_tab  [2][MAX_ENTRIES];
   logic [ADDR_W-1:0]  hi_tab  [2][MAX_ENTRIES];
   logic [LABEL_W-1:0] tag_tab [2][MAX_ENTRIES];
   int                 count_of [2] = '{0, 0};
   logic [LABEL_W-1:0] top_of   [2] = '{'0, '0};

   map_cmd_t   cmd_backlog[$];
   map_reply_t replies_due[$];
   map_cmd_t   on_bus;

   int idle_mode    = IDLE_NONE;
   int hold_asks    = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int faults       = 0;
   int results_seen = 0;
   int cycles       = 0;

   range_map_split_relabel_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // table predictor
   // ---------------------------------------------------------------------
   function automatic void append_slot(input int side, input logic [ADDR_W-1:0] s,
                                       input logic [ADDR_W-1:0] e,
                                       input logic [LABEL_W-1:0] l);
      lo_tab[side][count_of[side]]  = s;
      hi_tab[side][count_of[side]]  = e;
      tag_tab[side][count_of[side]] = l;
      count_of[side]++;
   endfunction

   function automatic map_reply_t map_step(input int side, input map_cmd_t c);
      map_reply_t         r;
      logic [ADDR_W-1:0]  s, e, es, ee;
      logic [LABEL_W-1:0] keep;
      int                 hit;
      int                 i;
      bit                 seen;
      r = '0;
      case (c.op)
         OP_APPEND: begin
            if (count_of[side] >= MAX_ENTRIES) r.status = ST_FULL;
            else append_slot(side, c.range_start, c.range_end, c.new_label);
         end
         OP_RELABEL: begin
            s = c.range_start;
            e = c.range_end;
            if (s > e) begin
               s = c.range_end;
               e = c.range_start;
            end
            e = e - 1'b1;
            // first entry with the old label that holds the whole range
            hit  = -1;
            seen = 1'b0;
            for (i = 0; i < count_of[side]; i++) begin
               if (hit < 0 && tag_tab[side][i] == c.old_label) begin
                  seen = 1'b1;
                  if (lo_tab[side][i] <= s && hi_tab[side][i] >= e) hit = i;
               end
            end
            if (hit < 0) begin
               r.status = seen ? ST_OUTSIDE : ST_INVALID;
            end else begin
               es   = lo_tab[side][hit];
               ee   = hi_tab[side][hit];
               keep = tag_tab[side][hit];
               if (s == es && e == ee) begin
                  tag_tab[side][hit] = c.new_label;
               end else if (s == es || e == ee) begin
                  if (count_of[side] + 1 > MAX_ENTRIES) begin
                     r.status = ST_FULL;
                  end else begin
                     if (s == es) lo_tab[side][hit] = e + 1'b1;
                     else hi_tab[side][hit] = s - 1'b1;
                     append_slot(side, s, e, c.new_label);
                  end
               end else if (count_of[side] + 2 > MAX_ENTRIES) begin
                  r.status = ST_FULL;
               end else begin
                  append_slot(side, s, e, c.new_label);
                  append_slot(side, e + 1'b1, ee, keep);
                  hi_tab[side][hit] = s - 1'b1;
               end
               if (r.status == ST_OK && top_of[side] < c.new_label)
                  top_of[side] = c.new_label;
            end
         end
         OP_READ: begin
            if (c.index < count_of[side]) begin
               r.slot_start = lo_tab[side][c.index];
               r.slot_end   = hi_tab[side][c.index];
               r.slot_label = tag_tab[side][c.index];
            end else begin
               r.status = ST_INVALID;
            end
         end
         default: r.status = ST_INVALID;
      endcase
      r.entry_total   = CNT_W'(count_of[side]);
      r.largest_label = top_of[side];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // word generation against the planning copy
   // ---------------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // address in [a, b], with the ends favored
   function automatic logic [ADDR_W-1:0] pick_between(input logic [ADDR_W-1:0] a,
                                                      input logic [ADDR_W-1:0] b);
      logic [ADDR_W-1:0] span;
      int                roll;
      roll = $urandom_range(0, 3);
      span = b - a + 1'b1;
      if (roll == 0) return a;
      if (roll == 1) return b;
      if (span == 0) return rand64();
      return a + rand64() % span;
   endfunction

   // mostly a small shared pool, sometimes a step above the high mark
   function automatic logic [LABEL_W-1:0] fresh_label();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 72) return LABEL_W'($urandom_range(0, 63));
      if (roll < 97) return top_of[PLAN] + LABEL_W'($urandom_range(1, 4));
      return LABEL_W'($urandom);
   endfunction

   task automatic issue(input logic [1:0] op, input logic [ADDR_W-1:0] s,
                        input logic [ADDR_W-1:0] e, input logic [LABEL_W-1:0] nl,
                        input logic [LABEL_W-1:0] ol, input logic [SEL_W-1:0] idx);
      map_cmd_t c;
      c = {op, idx, ol, nl, e, s};
      void'(map_step(PLAN, c));
      cmd_backlog.push_back(c);
   endtask

   task automatic append_random();
      logic [ADDR_W-1:0]  lo;
      logic [LABEL_W-1:0] tag;
      int                 roll;
      roll = $urandom_range(0, 99);
      lo   = rand64();
      tag  = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom)
                                          : LABEL_W'($urandom_range(0, 63));
      if (roll < 8) issue(OP_APPEND, '0, ALL_ONES, tag, LABEL_W'($urandom), '0);
      else if (roll < 13) issue(OP_APPEND, lo, rand64(), tag, LABEL_W'($urandom), '0);
      else issue(OP_APPEND, lo, lo + (rand64() >> $urandom_range(1, 63)), tag,
                 LABEL_W'($urandom), SEL_W'($urandom));
   endtask

   // relabel a piece of a live entry, ends given either way round
   task automatic relabel_inside(input int cut);
      int                slot;
      logic [ADDR_W-1:0] es, ee, s, e;
      slot = $urandom_range(0, count_of[PLAN] - 1);
      es   = lo_tab[PLAN][slot];
      ee   = hi_tab[PLAN][slot];
      if (es > ee) ee = es;
      case (cut)
         CUT_WHOLE: begin
            s = es;
            e = ee;
         end
         CUT_LEFT: begin
            s = es;
            e = pick_between(es, ee);
         end
         CUT_RIGHT: begin
            s = pick_between(es, ee);
            e = ee;
         end
         default: begin
            s = pick_between(es, ee);
            e = pick_between(s, ee);
         end
      endcase
      if ($urandom_range(0, 3) == 0)
         issue(OP_RELABEL, e + 1'b1, s, fresh_label(), tag_tab[PLAN][slot], SEL_W'($urandom));
      else
         issue(OP_RELABEL, s, e + 1'b1, fresh_label(), tag_tab[PLAN][slot], SEL_W'($urandom));
   endtask

   task automatic random_words(input int n, input int done_before);
      int  k, roll, slot, top_idx;
      bit  room;
      for (k = 0; k < n; k++) begin
         // growth is rationed so the table fills only near the end
         room    = count_of[PLAN] < 4 + ((done_before + k) * 60) / RANDOM_WORDS;
         roll    = $urandom_range(0, 99);
         slot    = (count_of[PLAN] > 0) ? $urandom_range(0, count_of[PLAN] - 1) : 0;
         top_idx = (count_of[PLAN] > MAX_ENTRIES - 1) ? MAX_ENTRIES - 1 : count_of[PLAN];
         if (count_of[PLAN] == 0 || (roll < 10 && room)) begin
            append_random();
         end else if (roll < 60) begin
            relabel_inside(room ? $urandom_range(CUT_WHOLE, CUT_MIDDLE) : CUT_WHOLE);
         end else if (roll < 70) begin
            // loose range, label from the table or anything
            issue(OP_RELABEL, rand64(), rand64(), LABEL_W'($urandom),
                  $urandom_range(0, 1) ? tag_tab[PLAN][slot] : LABEL_W'($urandom),
                  SEL_W'($urandom));
         end else if (roll < 75) begin
            // right label, range hanging off the low end of the entry
            issue(OP_RELABEL, lo_tab[PLAN][slot] - 1'b1,
                  pick_between(lo_tab[PLAN][slot], hi_tab[PLAN][slot]) + 1'b1,
                  fresh_label(), tag_tab[PLAN][slot], SEL_W'($urandom));
         end else if (roll < 95) begin
            issue(OP_READ, rand64(), rand64(), LABEL_W'($urandom), LABEL_W'($urandom),
                  ($urandom_range(0, 4) == 0) ? SEL_W'($urandom_range(0, MAX_ENTRIES - 1))
                                              : SEL_W'($urandom_range(0, top_idx)));
         end else begin
            issue(OP_SPARE, rand64(), rand64(), LABEL_W'($urandom), LABEL_W'($urandom),
                  SEL_W'($urandom));
         end
      end
   endtask

   // wait until every queued word has been sent and answered
   task automatic drain();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || replies_due.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // request driver: predicts each word as it is accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) replies_due.push_back(map_step(CHECK, on_bus));
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 60) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 20))) begin
               on_bus = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({on_bus.index, on_bus.old_label, on_bus.new_label,
                                          on_bus.range_end, on_bus.range_start});
               req_tuser  <= on_bus.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // ---------------------------------------------------------------------
   // response monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      map_reply_t got;
      map_reply_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser,
                   rsp_tdata[CNT_W + LABEL_W + 2 * ADDR_W +: LABEL_W],
                   rsp_tdata[CNT_W + LABEL_W + ADDR_W +: ADDR_W],
                   rsp_tdata[CNT_W + LABEL_W +: ADDR_W],
                   rsp_tdata[CNT_W +: LABEL_W],
                   rsp_tdata[CNT_W-1:0]};
            if (replies_due.size() == 0) begin
               faults++;
               if (faults <= REPORT_MAX)
                  $display("word %0d: response with none outstanding", results_seen);
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  faults++;
                  if (faults <= REPORT_MAX) begin
                     $display("word %0d mismatch (exp/got): status %0d/%0d total %0d/%0d",
                              results_seen, want.status, got.status, want.entry_total,
                              got.entry_total);
                     $display("   top %h/%h start %h/%h end %h/%h label %h/%h",
                              want.largest_label, got.largest_label,
                              want.slot_start, got.slot_start, want.slot_end, got.slot_end,
                              want.slot_label, got.slot_label);
                  end
               end
            end
            results_seen++;
         end
         rsp_tready <= hold_left == 0 &&
                       !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 60) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 20));
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      int p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, unused op
      issue(OP_READ, '0, '0, '0, '0, '0);
      issue(OP_RELABEL, 64'h10, 64'h20, 16'h1, 16'h0, '0);
      issue(OP_SPARE, ALL_ONES, ALL_ONES, '1, '1, '1);
      // whole address space plus one small entry
      issue(OP_APPEND, '0, ALL_ONES, 16'h5, '0, '0);
      issue(OP_APPEND, 64'h1000, 64'h1FFF, 16'h7, '0, '0);
      issue(OP_READ, '0, '0, '0, '0, 6'd0);
      issue(OP_READ, '0, '0, '0, '0, 6'd1);
      // label missing, then found but range sticks out
      issue(OP_RELABEL, 64'h1000, 64'h1100, 16'h20, 16'h9, '0);
      issue(OP_RELABEL, 64'h800, 64'h1800, 16'h20, 16'h7, '0);
      // whole, left cut, right cut, middle cut
      issue(OP_RELABEL, 64'h1000, 64'h2000, 16'h10, 16'h7, '0);
      issue(OP_RELABEL, 64'h1000, 64'h1100, 16'h11, 16'h10, '0);
      issue(OP_RELABEL, 64'h1F00, 64'h2000, 16'h12, 16'h10, '0);
      issue(OP_RELABEL, 64'h1400, 64'h1500, 16'h13, 16'h10, '0);
      // both ends zero wraps to the full space
      issue(OP_RELABEL, '0, '0, 16'h16, 16'h5, '0);
      // ends swapped, then an empty range
      issue(OP_RELABEL, 64'h200, 64'h100, 16'h17, 16'h16, '0);
      issue(OP_RELABEL, 64'h300, 64'h300, 16'h18, 16'h16, '0);
      // entry stored with reversed ends, read back and missed
      issue(OP_APPEND, ALL_ONES, '0, 16'hFFFF, '0, '0);
      issue(OP_READ, '0, '0, '0, '0, SEL_W'(count_of[PLAN] - 1));
      issue(OP_RELABEL, 64'h5, 64'h6, 16'h8000, 16'hFFFF, '0);
      issue(OP_READ, '0, '0, '0, '0, 6'd63);
      drain();

      // random phases; the first one opens with a long receiver hold-off
      for (p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
         idle_mode = p;
         if (p == IDLE_NONE) hold_asks++;
         random_words(RANDOM_WORDS / 4, p * (RANDOM_WORDS / 4));
         drain();
      end

      // fill the table and hit the full cases
      while (count_of[PLAN] < MAX_ENTRIES - 2) append_random();
      issue(OP_APPEND, 64'h100_0000, 64'h100_FFFF, 16'hABCD, '0, '0);
      issue(OP_RELABEL, 64'h100_1000, 64'h100_2000, 16'h40, 16'hABCD, '0);
      issue(OP_RELABEL, 64'h100_0000, 64'h100_0100, 16'h41, 16'hABCD, '0);
      issue(OP_APPEND, 64'h42, 64'h43, 16'h42, '0, '0);
      issue(OP_RELABEL, 64'h100_F000, 64'h101_0000, 16'h43, 16'hABCD, '0);
      issue(OP_RELABEL, 64'h100_0100, 64'h101_0000, 16'hFFFF, 16'hABCD, '0);
      issue(OP_READ, '0, '0, '0, '0, 6'd63);
      issue(OP_READ, '0, '0, '0, '0, 6'd62);
      random_words(40, RANDOM_WORDS);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rmsr_pkg.sv
hdl/rmsr_ram.sv
hdl/range_map_split_relabel_core.sv
sim/range_map_split_relabel_core_test.sv
